// ===== hw/rtl/wvo_pkg.sv =====
// Shared types, constants and the quarter-wave sine ROM for the voice oscillator.
// Depends on nothing; the oscillator and the multiplier files import it.
package wvo_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_ABITS  = $clog2(SINE_DEPTH);

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int STEP_RSH_BASE = 54 - PHASE_BITS;

  localparam logic [16:0] TAIL_ONE   = 17'd65536;
  localparam logic [15:0] TAIL_DECAY = 16'd64881;
  localparam logic [16:0] TAIL_STOP  = 17'd3276;

  localparam logic [1:0]  WAVEFORM_RESET  = 2'd0;
  localparam logic [15:0] LEVEL_RESET     = 16'd32768;
  localparam logic [30:0] BASE_INC_RESET  = 31'd39370533;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_RELEASE = 2'd2,
    OP_STOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    REG_WAVEFORM = 2'd0,
    REG_LEVEL    = 2'd1,
    REG_BASE_INC = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WAVE,
    ST_GAIN,
    ST_DECAY,
    ST_TAIL,
    ST_EMIT
  } state_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];
  typedef logic [16:0] ratio_rom_t [12];

  // 2^(semi/12) in Q16.
  localparam ratio_rom_t SEMITONE_Q16 = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  // Entry i is round(32767*sin(pi/2*(2i+1)/(2*DEPTH))), built with a Q30 Taylor
  // series up to the x^13 term, evaluated once at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint sum;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * 64'(2 * i + 1)) / 64'(2 * SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = v[14:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Octave of d = note + 3 (d at most 130): d / 12 through a reciprocal.
  function automatic logic [3:0] octave_of(input logic [7:0] d);
    logic [13:0] prod;
    prod = 14'(d) * 14'd43;
    return prod[12:9];
  endfunction

endpackage

// ===== hw/rtl/wvo_channels.sv =====
// Valid/ready channel interfaces for the voice oscillator's input and result beats.
// Depends on nothing; it imports no package.
interface wvo_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] note;

  modport source (output valid, output op, output note, input ready);
  modport sink   (input valid, input op, input note, output ready);
endinterface

interface wvo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        voice_active;

  modport source (output valid, output sample, output voice_active, input ready);
  modport sink   (input valid, input sample, input voice_active, output ready);
endinterface

// ===== hw/rtl/waveform_voice_oscillator.sv =====
// Phase-accumulator synthesizer voice: one shared 32x17 multiplier under a sequencer.
// A tick beat on a sounding voice runs the wave, gain, decay, tail and emit steps, on an
// idle one only emit; a note-on beat runs the step state, and release and stop none.
// Throughput: one beat at a time; the multiplier is used up to three times per tick.
// Reset (rst_n low, synchronous) silences the voice and restores register defaults.
module waveform_voice_oscillator
  import wvo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wvo_in_if.sink      in_bus,
  wvo_out_if.source   out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [1:0]  waveform_r;
  logic [15:0] level_r;
  logic [30:0] base_inc_r;

  // Voice state.
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [16:0]           tail_r;
  logic                  releasing_r;
  logic                  active_r;

  // Per-beat working registers.
  state_t      state_r;
  state_t      state_nxt;
  logic [3:0]  oct_r;
  logic        neg_r;
  logic [15:0] sample_r;

  // Result register; it holds a finished beat until the sink takes it.
  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic        out_active_r;

  // Shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  wvo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // APB configuration port. Writes land in the access phase; pready is tied high.
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_WAVEFORM: prdata = {30'd0, waveform_r};
      REG_LEVEL:    prdata = {16'd0, level_r};
      REG_BASE_INC: prdata = {1'b0, base_inc_r};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r <= WAVEFORM_RESET;
      level_r    <= LEVEL_RESET;
      base_inc_r <= BASE_INC_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WAVEFORM: waveform_r <= pwdata[1:0];
        REG_LEVEL:    level_r    <= pwdata[15:0];
        REG_BASE_INC: base_inc_r <= pwdata[30:0];
        default:      ;
      endcase
    end
  end

  // Note number to octave and semitone; d = note + 3 so that note 69 sits on semitone 0.
  logic [7:0] note_d;
  logic [3:0] note_oct;
  logic [7:0] note_semi;

  assign note_d    = 8'(in_bus.note) + 8'd3;
  assign note_oct  = octave_of(note_d);
  assign note_semi = note_d - 8'(note_oct) * 8'd12;

  // Phase step: the base increment times the semitone ratio, scaled by the octave.
  // Bits shifted out to the right are dropped and the result wraps to the phase width.
  logic [63:0]           step_wide;
  logic [PHASE_BITS-1:0] step_new;

  always_comb begin
    if (STEP_RSH_BASE >= int'(oct_r)) begin
      step_wide = 64'(mul_p) >> (STEP_RSH_BASE - int'(oct_r));
    end else begin
      step_wide = 64'(mul_p) << (int'(oct_r) - STEP_RSH_BASE);
    end
    step_new = step_wide[PHASE_BITS-1:0];
  end

  // Waveform generation from the current phase. Values span -32768 to +32768.
  localparam logic [PHASE_BITS-1:0] PHASE_HALF    = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [PHASE_BITS-1:0] PHASE_QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  logic [1:0]            quad;
  logic [SINE_ABITS-1:0] sine_idx;
  logic [14:0]           sine_val;
  logic [PHASE_BITS-1:0] saw_phase;
  logic [PHASE_BITS-1:0] tri_phase;
  logic [16:0]           tri_t;
  logic signed [17:0]    wave;
  logic                  wave_neg;
  logic [16:0]           wave_mag;

  assign quad      = phase_r[PHASE_BITS-1 -: 2];
  assign sine_idx  = quad[0] ? ~phase_r[PHASE_BITS-3 -: SINE_ABITS]
                             : phase_r[PHASE_BITS-3 -: SINE_ABITS];
  assign sine_val  = SINE_ROM[sine_idx];
  assign saw_phase = phase_r + PHASE_HALF;
  assign tri_phase = phase_r + PHASE_QUARTER;
  assign tri_t     = tri_phase[PHASE_BITS-1 -: 17];

  always_comb begin
    case (wave_t'(waveform_r))
      WAVE_SQUARE: begin
        if (!phase_r[PHASE_BITS-1] && (phase_r != '0)) begin
          wave = 18'sd32768;
        end else begin
          wave = -18'sd32768;
        end
      end
      WAVE_SAW: wave = $signed({2'b00, saw_phase[PHASE_BITS-1 -: 16]}) - 18'sd32768;
      WAVE_TRI: begin
        if (!tri_t[16]) begin
          wave = $signed({1'b0, tri_t}) - 18'sd32768;
        end else begin
          wave = 18'sd98304 - $signed({1'b0, tri_t});
        end
      end
      default: begin
        if (quad[1]) begin
          wave = -$signed({3'b000, sine_val});
        end else begin
          wave = $signed({3'b000, sine_val});
        end
      end
    endcase
    wave_neg = wave[17];
    wave_mag = wave_neg ? 17'(-wave) : 17'(wave);
  end

  // Rounding and saturation of |wave| * level * gain (Q1.15 * Q1.15 * Q1.16 -> Q1.15).
  logic [MUL_P_W:0]        round_sum;
  logic [MUL_P_W-31:0]     round_mag;
  logic [15:0]             sample_new;

  assign round_sum = {1'b0, mul_p} + (MUL_P_W+1)'(1 << 30);
  assign round_mag = round_sum[MUL_P_W:31];

  always_comb begin
    if (neg_r) begin
      if (round_mag > (MUL_P_W-30)'(32768)) begin
        sample_new = 16'h8000;
      end else begin
        sample_new = 16'(-round_mag);
      end
    end else begin
      if (round_mag > (MUL_P_W-30)'(32767)) begin
        sample_new = 16'h7FFF;
      end else begin
        sample_new = round_mag[15:0];
      end
    end
  end

  // Tail gain after one decay step; the product is tail * 0.99 in Q16.
  logic [16:0] tail_new;
  assign tail_new = mul_p[32:16];

  // Sequencer: next state.
  logic in_fire;
  assign in_fire = in_bus.valid && in_bus.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_bus.op))
            OP_NOTE_ON: state_nxt = ST_STEP;
            OP_TICK:    state_nxt = active_r ? ST_WAVE : ST_EMIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STEP:  state_nxt = ST_IDLE;
      ST_WAVE:  state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_DECAY;
      ST_DECAY: state_nxt = ST_TAIL;
      ST_TAIL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs. The multiplier operands follow the state.
  always_comb begin
    in_bus.ready = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        mul_a        = MUL_A_W'(base_inc_r);
        mul_b        = SEMITONE_Q16[note_semi[3:0]];
      end
      ST_WAVE: begin
        mul_a = MUL_A_W'(wave_mag);
        mul_b = MUL_B_W'(level_r);
      end
      ST_GAIN: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = releasing_r ? tail_r : TAIL_ONE;
      end
      ST_DECAY: begin
        mul_a = MUL_A_W'(tail_r);
        mul_b = MUL_B_W'(TAIL_DECAY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Voice state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= '0;
      tail_r      <= '0;
      releasing_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (op_t'(in_bus.op))
              OP_NOTE_ON: begin
                phase_r     <= '0;
                tail_r      <= '0;
                releasing_r <= 1'b0;
                active_r    <= 1'b1;
              end
              OP_RELEASE: begin
                if (active_r && !releasing_r) begin
                  releasing_r <= 1'b1;
                  tail_r      <= TAIL_ONE;
                end
              end
              OP_STOP: begin
                active_r    <= 1'b0;
                releasing_r <= 1'b0;
                tail_r      <= '0;
                phase_r     <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_STEP:  step_r  <= step_new;
        ST_DECAY: phase_r <= phase_r + step_r;
        ST_TAIL: begin
          if (releasing_r) begin
            if (tail_new <= TAIL_STOP) begin
              active_r    <= 1'b0;
              releasing_r <= 1'b0;
              tail_r      <= '0;
              step_r      <= '0;
            end else begin
              tail_r <= tail_new;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        oct_r    <= note_oct;
        sample_r <= '0;
      end
      ST_WAVE:  neg_r    <= wave_neg;
      ST_DECAY: sample_r <= sample_new;
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && (!out_valid_r || out_bus.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && (!out_valid_r || out_bus.ready)) begin
      out_sample_r <= sample_r;
      out_active_r <= active_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.sample       = out_sample_r;
  assign out_bus.voice_active = out_active_r;

`ifndef SYNTHESIS
  // A silent voice carries no release and no tail.
  assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (!releasing_r && (tail_r == '0)))
    else $error("idle voice holds release state");

  // Release only ever runs on a sounding voice.
  assert property (@(posedge clk) disable iff (!rst_n)
    releasing_r |-> active_r)
    else $error("releasing without an active voice");

  // A hard stop silences the voice on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_bus.op == OP_STOP)) |=> !active_r)
    else $error("hard stop did not silence the voice");

  // The sequencer never leaves the emit step while a result is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_valid_r && !out_bus.ready) |=> (state_r == ST_EMIT))
    else $error("result dropped while the sink stalled");
`endif

endmodule

// ===== hw/rtl/wvo_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on wvo_pkg for the operand widths.
module wvo_mul
  import wvo_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
